### rtl/itr_pkg.sv
package itr_pkg;

   localparam int VALUE_WIDTH  = 32;
   localparam int RADIX_WIDTH  = 6;
   localparam int CHAR_WIDTH   = 7;
   localparam int DIGIT_WIDTH  = 6;
   localparam int STACK_DEPTH  = VALUE_WIDTH;
   localparam int BIT_WIDTH    = $clog2(VALUE_WIDTH);
   localparam int DEPTH_WIDTH  = $clog2(STACK_DEPTH + 1);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN    = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX    = RADIX_WIDTH'(36);
   localparam logic [RADIX_WIDTH-1:0] RADIX_SIGNED = RADIX_WIDTH'(10);

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = CHAR_WIDTH'(0);
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = CHAR_WIDTH'(45);
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = CHAR_WIDTH'(48);
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = CHAR_WIDTH'(87);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [RADIX_WIDTH-1:0]        radix;
   } req_beat_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } rsp_beat_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] mag;
      logic [RADIX_WIDTH-1:0] radix;
      logic                   neg;
      logic                   ok;
   } job_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] dx;
      dx = CHAR_WIDTH'(d);
      if (d < DIGIT_WIDTH'(10)) begin
         return CHAR_ZERO + dx;
      end
      return CHAR_ALPHA + dx;
   endfunction

endpackage

### rtl/itr_front.sv
module itr_front (
   input  logic                 start,
   input  logic                 busy,
   input  itr_pkg::req_beat_type req_beat,
   output logic                 push,
   output itr_pkg::job_type     job
);

   localparam int VW = itr_pkg::VALUE_WIDTH;
   localparam logic [VW-1:0] ONE_V = VW'(1);

   logic [VW-1:0] raw;
   logic          ok;
   logic          neg;

   assign raw  = req_beat.value;
   assign ok   = (req_beat.radix >= itr_pkg::RADIX_MIN) && (req_beat.radix <= itr_pkg::RADIX_MAX);
   assign neg  = ok && (req_beat.radix == itr_pkg::RADIX_SIGNED) && raw[VW-1];
   assign push = start && !busy;

   always_comb begin
      job.mag   = neg ? (~raw + ONE_V) : raw;
      job.radix = req_beat.radix;
      job.neg   = neg;
      job.ok    = ok;
   end

endmodule

### rtl/itr_queue.sv
module itr_queue #(
   parameter int DEPTH = itr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  itr_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output itr_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   itr_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/itr_back.sv
module itr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  itr_pkg::job_type      job,
   output logic                  pop,
   output logic                  rsp_strobe,
   output itr_pkg::rsp_beat_type rsp_beat
);

   localparam int VW  = itr_pkg::VALUE_WIDTH;
   localparam int RW  = itr_pkg::RADIX_WIDTH;
   localparam int DW  = itr_pkg::DIGIT_WIDTH;
   localparam int BW  = itr_pkg::BIT_WIDTH;
   localparam int NW  = itr_pkg::DEPTH_WIDTH;
   localparam int SD  = itr_pkg::STACK_DEPTH;
   localparam logic [BW-1:0] BIT_LAST = BW'(VW - 1);
   localparam logic [NW-1:0] DEPTH_ONE = NW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT,
      ST_TERM
   } state_type;

   state_type             state_ff;
   logic [VW-1:0]         work_ff;
   logic [DW-1:0]         rem_ff;
   logic [RW-1:0]         radix_ff;
   logic                  neg_ff;
   logic [BW-1:0]         bit_ff;
   logic [NW-1:0]         depth_ff;
   logic [DW-1:0]         stack_ff [SD];
   logic                  rsp_strobe_ff;
   itr_pkg::rsp_beat_type rsp_beat_ff;

   logic [DW:0]   shifted;
   logic          ge;
   logic [DW:0]   rem_step;
   logic [VW-1:0] work_step;
   logic          digit_done;
   logic          do_push;
   logic          do_pop;

   assign shifted    = {rem_ff, work_ff[VW-1]};
   assign ge         = (shifted >= {1'b0, radix_ff});
   assign rem_step   = ge ? (shifted - {1'b0, radix_ff}) : shifted;
   assign work_step  = {work_ff[VW-2:0], ge};
   assign digit_done = (state_ff == ST_DIVIDE) && (bit_ff == BIT_LAST);
   assign do_push    = digit_done;
   assign do_pop     = (state_ff == ST_EMIT);
   assign pop        = (state_ff == ST_IDLE) && job_valid;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_beat   = rsp_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         depth_ff      <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  work_ff  <= job.mag;
                  radix_ff <= job.radix;
                  neg_ff   <= job.neg;
                  rem_ff   <= '0;
                  bit_ff   <= '0;
                  depth_ff <= '0;
                  if (job.ok) begin
                     state_ff <= ST_DIVIDE;
                  end else begin
                     rsp_strobe_ff         <= 1'b1;
                     rsp_beat_ff.character <= itr_pkg::CHAR_NUL;
                     rsp_beat_ff.last      <= 1'b1;
                  end
               end
            end
            ST_DIVIDE: begin
               work_ff <= work_step;
               if (digit_done) begin
                  rem_ff   <= '0;
                  bit_ff   <= '0;
                  depth_ff <= depth_ff + DEPTH_ONE;
                  if (work_step == '0) begin
                     state_ff <= neg_ff ? ST_SIGN : ST_EMIT;
                  end
               end else begin
                  rem_ff <= rem_step[DW-1:0];
                  bit_ff <= bit_ff + BW'(1);
               end
            end
            ST_SIGN: begin
               rsp_strobe_ff         <= 1'b1;
               rsp_beat_ff.character <= itr_pkg::CHAR_MINUS;
               rsp_beat_ff.last      <= 1'b0;
               state_ff              <= ST_EMIT;
            end
            ST_EMIT: begin
               rsp_strobe_ff         <= 1'b1;
               rsp_beat_ff.character <= itr_pkg::digit_char(stack_ff[0]);
               rsp_beat_ff.last      <= 1'b0;
               depth_ff              <= depth_ff - DEPTH_ONE;
               if (depth_ff == DEPTH_ONE) begin
                  state_ff <= ST_TERM;
               end
            end
            ST_TERM: begin
               rsp_strobe_ff         <= 1'b1;
               rsp_beat_ff.character <= itr_pkg::CHAR_NUL;
               rsp_beat_ff.last      <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_ff[0] <= rem_step[DW-1:0];
         for (int i = 1; i < SD; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (do_pop) begin
         for (int i = 0; i < SD - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
         stack_ff[SD-1] <= '0;
      end
   end

endmodule

### rtl/integer_to_radix_text.sv
// Channel   Direction  Handshake           Beat
// request   in         start, busy         req_beat: value, radix
// response  out        rsp_strobe          rsp_beat: character, last
//
// Each digit is worked out on a restoring bit-serial divider.
// With the sequencer idle, a bad radix passes the queue register and then the
// sequencer's response register before its terminator goes out.
// Reset is synchronous and clears the queue and the sequencer.
// Busy rises only while the queue in front of the divider (two entries by default) is full.
// Characters of one run leave on consecutive cycles and cannot be held off.
module integer_to_radix_text #(
   parameter int QUEUE_DEPTH = itr_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  itr_pkg::req_beat_type req_beat,
   output logic                  rsp_strobe,
   output itr_pkg::rsp_beat_type rsp_beat
);

   logic             push;
   itr_pkg::job_type push_job;
   logic             pop;
   logic             full;
   logic             not_empty;
   itr_pkg::job_type head_job;

   assign busy = full;

   itr_front u_front (
      .start    (start),
      .busy     (busy),
      .req_beat (req_beat),
      .push     (push),
      .job      (push_job)
   );

   itr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   itr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (not_empty),
      .job        (head_job),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat)
   );

   a_run_contiguous : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_beat.last |=> rsp_strobe)
      else $error("Response run broke before its last beat.");

   a_last_is_nul : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_beat.last == (rsp_beat.character == itr_pkg::CHAR_NUL)))
      else $error("Terminator and last flag disagree.");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("Outputs active right after reset.");

endmodule
